@@ hdl/bal_pkg.sv @@
// Shared types, constants and fixed-point helpers for the bias/activation
// layout unit. No dependencies.
`default_nettype none

package bal_pkg;

  localparam int VALUE_W          = 32;
  localparam int ADDR_W           = 24;
  localparam int MODE_W           = 3;
  localparam int PLANE_CFG_W      = 17;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 32;
  localparam int LANES_DEF        = 8;
  localparam int MAX_CHANNELS_DEF = 256;
  localparam int MAX_PLANE_DEF    = 65536;
  localparam int QUEUE_DEPTH      = 4;

  typedef enum logic [MODE_W-1:0] {
    ACT_IDENT  = 3'd0,
    ACT_RELU   = 3'd1,
    ACT_CLIP   = 3'd2,
    ACT_LEAKY  = 3'd3,
    ACT_HSWISH = 3'd4
  } act_mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ACT_MODE        = 3'd0,
    CFG_PLANE_SIZE      = 3'd1,
    CFG_CLIP_LEVEL      = 3'd2,
    CFG_LEAK_SLOPE      = 3'd3,
    CFG_SWISH_OFFSET    = 3'd4,
    CFG_SWISH_INV_SCALE = 3'd5,
    CFG_SWISH_LIMIT     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [MODE_W-1:0]             act_mode;
    logic [PLANE_CFG_W-1:0]        plane_size;
    logic signed [VALUE_W-1:0]     clip_level;
    logic signed [VALUE_W-1:0]     leak_slope;
    logic signed [VALUE_W-1:0]     swish_offset;
    logic signed [VALUE_W-1:0]     swish_inv_scale;
    logic signed [VALUE_W-1:0]     swish_limit;
  } cfg_t;

  localparam logic [MODE_W-1:0]         RST_ACT_MODE        = ACT_IDENT;
  localparam logic [PLANE_CFG_W-1:0]    RST_PLANE_SIZE      = 17'd1;
  localparam logic signed [VALUE_W-1:0] RST_CLIP_LEVEL      = 32'sd393216;
  localparam logic signed [VALUE_W-1:0] RST_LEAK_SLOPE      = 32'sd6554;
  localparam logic signed [VALUE_W-1:0] RST_SWISH_OFFSET    = 32'sd196608;
  localparam logic signed [VALUE_W-1:0] RST_SWISH_INV_SCALE = 32'sd10923;
  localparam logic signed [VALUE_W-1:0] RST_SWISH_LIMIT     = 32'sd393216;

  function automatic logic signed [VALUE_W-1:0] sat_add(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b
  );
    logic signed [VALUE_W:0] s;
    s = $signed({a[VALUE_W-1], a}) + $signed({b[VALUE_W-1], b});
    if (s[VALUE_W] != s[VALUE_W-1]) begin
      return s[VALUE_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return s[VALUE_W-1:0];
  endfunction

  // Round to nearest, ties up, drop 16 fraction bits, saturate.
  function automatic logic signed [VALUE_W-1:0] mul_round_sat(
    input logic signed [2*VALUE_W-1:0] p
  );
    logic signed [2*VALUE_W-1:0] t;
    logic signed [47:0]          q;
    t = p + 64'sd32768;
    q = t[63:16];
    if (q > 48'sh0000_7fff_ffff) begin
      return 32'sh7fff_ffff;
    end
    if (q < 48'shffff_8000_0000) begin
      return 32'sh8000_0000;
    end
    return q[VALUE_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/bal_if.sv @@
// Valid/ready channel interfaces for the input and result beats.
// Depends on bal_pkg.
`default_nettype none

interface bal_in_if;
  import bal_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] in_value;
  logic signed [VALUE_W-1:0] bias_value;
  logic                      first_of_image;

  modport source (output valid, in_value, bias_value, first_of_image, input ready);
  modport sink (input valid, in_value, bias_value, first_of_image, output ready);
endinterface

interface bal_out_if;
  import bal_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] out_value;
  logic [ADDR_W-1:0]         out_address;

  modport source (output valid, out_value, out_address, input ready);
  modport sink (input valid, out_value, out_address, output ready);
endinterface

`default_nettype wire

@@ hdl/bias_activation_layout_unblock.sv @@
// Top level of the convolution post-processing unit: configuration registers,
// plane size clamp, front end, queue and back end. Depends on bal_pkg, bal_if.
//
// Use: elements arrive on in_ch in channel-blocked order (lane fastest, then
// position, then group), each with its channel's bias. An element with
// first_of_image set restarts the lane, position and group counters. Each
// element yields one beat on out_ch: bias added, activation applied in signed
// Q16.16, and its channel-major address (channel * plane + position, modulo
// 2^24). Registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the unit is empty, the block does not enforce it.
// Throughput: one element per cycle while out_ch does not stall. Each input
// beat passes the queue entry and the five-stage back end (two chained 32x32
// multiplies for hard swish, each followed by a rounding stage).
// Reset clears the counters, the queue and the pipeline and loads the register
// defaults. When out_ch stalls the back end holds; the four-entry queue keeps
// taking input until full, then in_ch.ready drops.
`default_nettype none

module bias_activation_layout_unblock #(
  parameter int  LANES        = bal_pkg::LANES_DEF,
  parameter int  MAX_CHANNELS = bal_pkg::MAX_CHANNELS_DEF,
  parameter int  MAX_PLANE    = bal_pkg::MAX_PLANE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  bal_in_if.sink                               in_ch,
  bal_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [bal_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bal_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bal_pkg::*;

  localparam int GROUPS = (MAX_CHANNELS / LANES > 1) ? MAX_CHANNELS / LANES : 1;
  localparam int POS_W  = $clog2(MAX_PLANE);
  localparam int PL_W   = $clog2(MAX_PLANE + 1);
  localparam int CH_W   = $clog2(GROUPS * LANES);
  localparam int QW     = 2 * VALUE_W + CH_W + POS_W;
  localparam int CMP_W  = (PL_W > PLANE_CFG_W) ? PL_W : PLANE_CFG_W;

  cfg_t             cfg_r, cfg_nxt;
  logic [CMP_W-1:0] ps_ext;
  logic [PL_W-1:0]  plane_eff;
  logic             q_push, q_full, q_pop, q_valid;
  logic [QW-1:0]    q_wr_data, q_rd_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ACT_MODE:        cfg_nxt.act_mode        = cfg_data[MODE_W-1:0];
        CFG_PLANE_SIZE:      cfg_nxt.plane_size      = cfg_data[PLANE_CFG_W-1:0];
        CFG_CLIP_LEVEL:      cfg_nxt.clip_level      = cfg_data;
        CFG_LEAK_SLOPE:      cfg_nxt.leak_slope      = cfg_data;
        CFG_SWISH_OFFSET:    cfg_nxt.swish_offset    = cfg_data;
        CFG_SWISH_INV_SCALE: cfg_nxt.swish_inv_scale = cfg_data;
        CFG_SWISH_LIMIT:     cfg_nxt.swish_limit     = cfg_data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.act_mode        <= RST_ACT_MODE;
      cfg_r.plane_size      <= RST_PLANE_SIZE;
      cfg_r.clip_level      <= RST_CLIP_LEVEL;
      cfg_r.leak_slope      <= RST_LEAK_SLOPE;
      cfg_r.swish_offset    <= RST_SWISH_OFFSET;
      cfg_r.swish_inv_scale <= RST_SWISH_INV_SCALE;
      cfg_r.swish_limit     <= RST_SWISH_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    ps_ext = CMP_W'(cfg_r.plane_size);
    if (ps_ext == '0) begin
      plane_eff = PL_W'(1);
    end else if (ps_ext > CMP_W'(MAX_PLANE)) begin
      plane_eff = PL_W'(MAX_PLANE);
    end else begin
      plane_eff = PL_W'(ps_ext);
    end
  end

  bal_front #(
    .LANES        (LANES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_PLANE    (MAX_PLANE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .plane_eff (plane_eff),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  bal_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd_data)
  );

  bal_back #(
    .LANES        (LANES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_PLANE    (MAX_PLANE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .plane_eff (plane_eff),
    .q_valid   (q_valid),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

@@ hdl/bal_front.sv @@
// Front end: accepts input beats, tracks lane/position/group counters and
// pushes value, bias, channel and position into the queue. Depends on bal_pkg.
`default_nettype none

module bal_front #(
  parameter int  LANES        = bal_pkg::LANES_DEF,
  parameter int  MAX_CHANNELS = bal_pkg::MAX_CHANNELS_DEF,
  parameter int  MAX_PLANE    = bal_pkg::MAX_PLANE_DEF,
  localparam int GROUPS  = (MAX_CHANNELS / LANES > 1) ? MAX_CHANNELS / LANES : 1,
  localparam int LANE_W  = $clog2(LANES),
  localparam int GRP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1,
  localparam int POS_W   = $clog2(MAX_PLANE),
  localparam int PL_W    = $clog2(MAX_PLANE + 1),
  localparam int CH_W    = $clog2(GROUPS * LANES),
  localparam int QW      = 2 * bal_pkg::VALUE_W + CH_W + POS_W
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  bal_in_if.sink               in_ch,
  input  wire logic [PL_W-1:0] plane_eff,
  input  wire logic            q_full,
  output logic                 q_push,
  output logic [QW-1:0]        q_data
);
  import bal_pkg::*;

  logic [LANE_W-1:0] lane_r, lane_nxt, lane_cur;
  logic [POS_W-1:0]  pos_r, pos_nxt, pos_cur;
  logic [GRP_W-1:0]  grp_r, grp_nxt, grp_cur;
  logic [LANE_W:0]   lane_inc;
  logic [PL_W-1:0]   pos_inc;
  logic [GRP_W:0]    grp_inc;
  logic [CH_W-1:0]   chan;

  assign in_ch.ready = rst_n && !q_full;
  assign q_push      = rst_n && in_ch.valid && !q_full;

  always_comb begin
    lane_cur = in_ch.first_of_image ? '0 : lane_r;
    pos_cur  = in_ch.first_of_image ? '0 : pos_r;
    grp_cur  = in_ch.first_of_image ? '0 : grp_r;
    chan     = CH_W'(grp_cur) * CH_W'(LANES) + CH_W'(lane_cur);
    lane_inc = {1'b0, lane_cur} + 1'b1;
    pos_inc  = PL_W'(pos_cur) + 1'b1;
    grp_inc  = {1'b0, grp_cur} + 1'b1;
    lane_nxt = lane_inc[LANE_W-1:0];
    pos_nxt  = pos_cur;
    grp_nxt  = grp_cur;
    if (lane_inc >= (LANE_W+1)'(LANES)) begin
      lane_nxt = '0;
      pos_nxt  = pos_inc[POS_W-1:0];
      if (pos_inc >= plane_eff) begin
        pos_nxt = '0;
        grp_nxt = grp_inc[GRP_W-1:0];
        if (grp_inc >= (GRP_W+1)'(GROUPS)) begin
          grp_nxt = '0;
        end
      end
    end
  end

  assign q_data = {in_ch.in_value, in_ch.bias_value, chan, pos_cur};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r <= '0;
      pos_r  <= '0;
      grp_r  <= '0;
    end else if (q_push) begin
      lane_r <= lane_nxt;
      pos_r  <= pos_nxt;
      grp_r  <= grp_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/bal_fifo.sv @@
// Small register queue between front and back end; DEPTH is a power of two.
// No dependencies.
`default_nettype none

module bal_fifo #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 4,
  localparam int PTR_W = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  rd_valid,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] entries_r [DEPTH];
  logic [PTR_W:0]   wr_ptr_r, rd_ptr_r;

  assign full     = (wr_ptr_r[PTR_W] != rd_ptr_r[PTR_W]) &&
                    (wr_ptr_r[PTR_W-1:0] == rd_ptr_r[PTR_W-1:0]);
  assign rd_valid = (wr_ptr_r != rd_ptr_r);
  assign rd_data  = entries_r[rd_ptr_r[PTR_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && rd_valid) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r[PTR_W-1:0]] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ hdl/bal_back.sv @@
// Back end: bias add, activation and address multiply in a stall-together
// pipeline ending in the output register. Depends on bal_pkg.
`default_nettype none

module bal_back #(
  parameter int  LANES        = bal_pkg::LANES_DEF,
  parameter int  MAX_CHANNELS = bal_pkg::MAX_CHANNELS_DEF,
  parameter int  MAX_PLANE    = bal_pkg::MAX_PLANE_DEF,
  localparam int GROUPS  = (MAX_CHANNELS / LANES > 1) ? MAX_CHANNELS / LANES : 1,
  localparam int POS_W   = $clog2(MAX_PLANE),
  localparam int PL_W    = $clog2(MAX_PLANE + 1),
  localparam int CH_W    = $clog2(GROUPS * LANES),
  localparam int AP_W    = CH_W + PL_W,
  localparam int QW      = 2 * bal_pkg::VALUE_W + CH_W + POS_W
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bal_pkg::cfg_t   cfg,
  input  wire logic [PL_W-1:0] plane_eff,
  input  wire logic            q_valid,
  input  wire logic [QW-1:0]   q_data,
  output logic                 q_pop,
  bal_out_if.source            out_ch
);
  import bal_pkg::*;

  logic signed [VALUE_W-1:0]   v_in, b_in;
  logic [CH_W-1:0]             chan_in;
  logic [POS_W-1:0]            pos_in;
  logic                        adv;

  logic                        v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic signed [VALUE_W-1:0]   x1_r, x2_r, x3_r, x4_r;
  logic [CH_W-1:0]             chan1_r;
  logic [POS_W-1:0]            pos1_r, pos2_r;
  logic signed [2*VALUE_W-1:0] p1_2_r, p2_4_r;
  logic signed [VALUE_W-1:0]   xo2_r, gate3_r, m1_3_r, m1_4_r;
  logic [AP_W-1:0]             aprod2_r;
  logic [ADDR_W-1:0]           addr3_r, addr4_r;
  logic signed [VALUE_W-1:0]   out_value_r;
  logic [ADDR_W-1:0]           out_address_r;

  logic signed [VALUE_W-1:0]   k2, g3, relu4, y_nxt;

  assign {v_in, b_in, chan_in, pos_in} = q_data;
  assign adv   = !out_valid_r || out_ch.ready;
  assign q_pop = adv;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_value   = out_value_r;
  assign out_ch.out_address = out_address_r;

  always_comb begin
    k2    = (cfg.act_mode == ACT_LEAKY) ? cfg.leak_slope : cfg.swish_inv_scale;
    g3    = xo2_r[VALUE_W-1] ? '0 : xo2_r;
    relu4 = x4_r[VALUE_W-1] ? '0 : x4_r;
    case (cfg.act_mode)
      ACT_RELU:   y_nxt = relu4;
      ACT_CLIP:   y_nxt = (relu4 < cfg.clip_level) ? relu4 : cfg.clip_level;
      ACT_LEAKY:  y_nxt = (x4_r > 32'sd0) ? x4_r : m1_4_r;
      ACT_HSWISH: y_nxt = mul_round_sat(p2_4_r);
      default:    y_nxt = x4_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= q_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r          <= sat_add(v_in, b_in);
      chan1_r       <= chan_in;
      pos1_r        <= pos_in;

      x2_r          <= x1_r;
      p1_2_r        <= x1_r * k2;
      xo2_r         <= sat_add(x1_r, cfg.swish_offset);
      aprod2_r      <= AP_W'(chan1_r) * AP_W'(plane_eff);
      pos2_r        <= pos1_r;

      x3_r          <= x2_r;
      m1_3_r        <= mul_round_sat(p1_2_r);
      gate3_r       <= (cfg.swish_limit < g3) ? cfg.swish_limit : g3;
      addr3_r       <= ADDR_W'(aprod2_r) + ADDR_W'(pos2_r);

      x4_r          <= x3_r;
      m1_4_r        <= m1_3_r;
      p2_4_r        <= gate3_r * m1_3_r;
      addr4_r       <= addr3_r;

      out_value_r   <= y_nxt;
      out_address_r <= addr4_r;
    end
  end

endmodule

`default_nettype wire

@@ sim/bias_activation_layout_unblock_test.sv @@
// Testbench for bias_activation_layout_unblock: streams elements and register writes,
// predicts every output beat (bias, activation, channel-major address) in a scoreboard
// and compares each field. Depends on bal_pkg, bal_if and the RTL top level.

import bal_pkg::*;

typedef struct {
  logic signed [VALUE_W-1:0] value;
  logic [ADDR_W-1:0]         address;
} post_beat_t;

class activation_scoreboard;
  logic [MODE_W-1:0]         act_mode;
  logic [PLANE_CFG_W-1:0]    plane_size;
  logic signed [VALUE_W-1:0] clip_level;
  logic signed [VALUE_W-1:0] leak_slope;
  logic signed [VALUE_W-1:0] swish_offset;
  logic signed [VALUE_W-1:0] swish_inv_scale;
  logic signed [VALUE_W-1:0] swish_limit;
  int                        lane_idx;
  int                        position_idx;
  int                        group_idx;
  post_beat_t                pending_beats[$];
  int                        errors;

  function new();
    act_mode        = RST_ACT_MODE;
    plane_size      = RST_PLANE_SIZE;
    clip_level      = RST_CLIP_LEVEL;
    leak_slope      = RST_LEAK_SLOPE;
    swish_offset    = RST_SWISH_OFFSET;
    swish_inv_scale = RST_SWISH_INV_SCALE;
    swish_limit     = RST_SWISH_LIMIT;
    lane_idx        = 0;
    position_idx    = 0;
    group_idx       = 0;
    errors          = 0;
  endfunction

  function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ACT_MODE:        act_mode = data[MODE_W-1:0];
      CFG_PLANE_SIZE:      plane_size = data[PLANE_CFG_W-1:0];
      CFG_CLIP_LEVEL:      clip_level = data;
      CFG_LEAK_SLOPE:      leak_slope = data;
      CFG_SWISH_OFFSET:    swish_offset = data;
      CFG_SWISH_INV_SCALE: swish_inv_scale = data;
      CFG_SWISH_LIMIT:     swish_limit = data;
      default: ;
    endcase
  endfunction

  function logic signed [VALUE_W-1:0] clamp_word(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< 31) - 1;
    lo = -(longint'(1) <<< 31);
    if (v > hi) return 32'sh7fff_ffff;
    if (v < lo) return 32'sh8000_0000;
    return v[VALUE_W-1:0];
  endfunction

  function logic signed [VALUE_W-1:0] add_q(logic signed [VALUE_W-1:0] a,
                                            logic signed [VALUE_W-1:0] b);
    return clamp_word(longint'(a) + longint'(b));
  endfunction

  // round half up, then floor-shift out the fraction
  function logic signed [VALUE_W-1:0] mul_q(logic signed [VALUE_W-1:0] a,
                                            logic signed [VALUE_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b) + 32768;
    return clamp_word(p >>> 16);
  endfunction

  function logic signed [VALUE_W-1:0] activate(logic signed [VALUE_W-1:0] x);
    logic signed [VALUE_W-1:0] pos;
    logic signed [VALUE_W-1:0] gate;
    pos = (x > 32'sd0) ? x : 32'sd0;
    case (act_mode)
      ACT_RELU:  return pos;
      ACT_CLIP:  return (pos < clip_level) ? pos : clip_level;
      ACT_LEAKY: return (x > 32'sd0) ? x : mul_q(x, leak_slope);
      ACT_HSWISH: begin
        gate = add_q(x, swish_offset);
        if (gate < 32'sd0) gate = 32'sd0;
        if (swish_limit < gate) gate = swish_limit;
        return mul_q(gate, mul_q(x, swish_inv_scale));
      end
      default:   return x;
    endcase
  endfunction

  function void note_element(logic signed [VALUE_W-1:0] in_value,
                             logic signed [VALUE_W-1:0] bias_value, logic first);
    int         plane;
    longint     chan;
    longint     addr;
    post_beat_t beat;
    plane = int'(plane_size);
    if (plane == 0) plane = 1;
    if (plane > MAX_PLANE_DEF) plane = MAX_PLANE_DEF;
    if (first) begin
      lane_idx     = 0;
      position_idx = 0;
      group_idx    = 0;
    end
    beat.value   = activate(add_q(in_value, bias_value));
    chan         = longint'(group_idx) * LANES_DEF + lane_idx;
    addr         = chan * plane + position_idx;
    beat.address = addr[ADDR_W-1:0];
    pending_beats.push_back(beat);
    lane_idx++;
    if (lane_idx >= LANES_DEF) begin
      lane_idx = 0;
      position_idx++;
      if (position_idx >= plane) begin
        position_idx = 0;
        group_idx++;
        if (group_idx >= MAX_CHANNELS_DEF / LANES_DEF) group_idx = 0;
      end
    end
  endfunction

  function int pending();
    return pending_beats.size();
  endfunction

  function void check_beat(logic signed [VALUE_W-1:0] value, logic [ADDR_W-1:0] address);
    post_beat_t want;
    if (pending_beats.size() == 0) begin
      errors++;
      $display("%0t: unexpected output beat: expected none actual value %h address %h",
               $time, value, address);
      return;
    end
    want = pending_beats.pop_front();
    if (value !== want.value) begin
      errors++;
      $display("%0t: out_value mismatch: expected %h actual %h", $time, want.value, value);
    end
    if (address !== want.address) begin
      errors++;
      $display("%0t: out_address mismatch: expected %h actual %h",
               $time, want.address, address);
    end
  endfunction
endclass

module bias_activation_layout_unblock_test;
  import bal_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int SETTLE_CYCLES = 8;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     cycle_count;

  activation_scoreboard sb = new();

  bal_in_if  in_ch();
  bal_out_if out_ch();

  bias_activation_layout_unblock uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** bias_activation_layout_unblock: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_element(in_ch.in_value, in_ch.bias_value, in_ch.first_of_image);
      if (out_ch.valid && out_ch.ready)
        sb.check_beat(out_ch.out_value, out_ch.out_address);
    end
  end

  // receiver: long ready runs, hard stalls and choppy stretches
  initial begin
    int   kind;
    int   len;
    logic level;
    out_ch.ready = 1'b0;
    forever begin
      kind  = $urandom_range(0, 3);
      level = (kind != 1);
      case (kind)
        0:       len = $urandom_range(20, 60);
        1:       len = $urandom_range(1, 10);
        2:       len = $urandom_range(5, 30);
        default: len = $urandom_range(1, 8);
      endcase
      repeat (len) begin
        @(negedge clk);
        out_ch.ready <= (kind == 2) ? 1'($urandom_range(0, 1)) : level;
      end
    end
  end

  function automatic logic signed [VALUE_W-1:0] rand_q();
    case ($urandom_range(0, 5))
      1:       return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      2:       return 32'h7fff_ffff - $urandom_range(0, 255);
      3:       return 32'h8000_0000 + $urandom_range(0, 255);
      4:       return $urandom_range(0, 512) - 256;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_element(input logic signed [VALUE_W-1:0] value,
                              input logic signed [VALUE_W-1:0] bias, input logic first);
    in_ch.valid          <= 1'b1;
    in_ch.in_value       <= value;
    in_ch.bias_value     <= bias;
    in_ch.first_of_image <= first;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_corners();
    push_element(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
    push_element(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    push_element(32'shffff_ffff, 32'sh0000_0000, 1'b0);
    push_element(32'sh0001_8000, 32'shfffe_0000, 1'b0);
  endtask

  task automatic run_phase(input logic [MODE_W-1:0] mode,
                           input logic [PLANE_CFG_W-1:0] plane,
                           input logic signed [VALUE_W-1:0] clip,
                           input logic signed [VALUE_W-1:0] leak,
                           input logic signed [VALUE_W-1:0] offset,
                           input logic signed [VALUE_W-1:0] inv_scale,
                           input logic signed [VALUE_W-1:0] limit,
                           input int count, input int restart_pct, input bit corners);
    int n;
    int burst;
    int gap;
    settle();
    write_cfg(CFG_ACT_MODE, CFG_DATA_W'(mode));
    write_cfg(CFG_PLANE_SIZE, CFG_DATA_W'(plane));
    write_cfg(CFG_CLIP_LEVEL, clip);
    write_cfg(CFG_LEAK_SLOPE, leak);
    write_cfg(CFG_SWISH_OFFSET, offset);
    write_cfg(CFG_SWISH_INV_SCALE, inv_scale);
    write_cfg(CFG_SWISH_LIMIT, limit);
    cfg_we <= 1'b0;
    if (corners) push_corners();
    n = 0;
    while (n < count) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
      for (int i = 0; i < burst && n < count; i++) begin
        push_element(rand_q(), rand_q(),
                     (n == 0) || ($urandom_range(1, 100) <= restart_pct));
        n++;
      end
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [PLANE_CFG_W-1:0] plane;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.in_value       = '0;
    in_ch.bias_value     = '0;
    in_ch.first_of_image = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_ACT_MODE;
    cfg_data             = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_phase(ACT_IDENT, 17'd1, RST_CLIP_LEVEL, RST_LEAK_SLOPE, RST_SWISH_OFFSET,
              RST_SWISH_INV_SCALE, RST_SWISH_LIMIT, 210, 0, 1'b1);
    run_phase(ACT_RELU, 17'd3, RST_CLIP_LEVEL, RST_LEAK_SLOPE, RST_SWISH_OFFSET,
              RST_SWISH_INV_SCALE, RST_SWISH_LIMIT, 70, 2, 1'b1);
    run_phase(ACT_CLIP, 17'd5, 32'sd163840, RST_LEAK_SLOPE, RST_SWISH_OFFSET,
              RST_SWISH_INV_SCALE, RST_SWISH_LIMIT, 70, 2, 1'b1);
    run_phase(ACT_CLIP, 17'd2, 32'shffff_0000, RST_LEAK_SLOPE, RST_SWISH_OFFSET,
              RST_SWISH_INV_SCALE, RST_SWISH_LIMIT, 40, 2, 1'b0);
    run_phase(ACT_LEAKY, 17'd2, RST_CLIP_LEVEL, RST_LEAK_SLOPE, RST_SWISH_OFFSET,
              RST_SWISH_INV_SCALE, RST_SWISH_LIMIT, 70, 2, 1'b1);
    run_phase(ACT_LEAKY, 17'd1, RST_CLIP_LEVEL, 32'sh7fff_ffff, RST_SWISH_OFFSET,
              RST_SWISH_INV_SCALE, RST_SWISH_LIMIT, 40, 1, 1'b0);
    run_phase(ACT_HSWISH, 17'd4, RST_CLIP_LEVEL, RST_LEAK_SLOPE, RST_SWISH_OFFSET,
              RST_SWISH_INV_SCALE, RST_SWISH_LIMIT, 100, 2, 1'b1);
    run_phase(ACT_HSWISH, 17'd3, RST_CLIP_LEVEL, 32'sh8000_0000, 32'sh7fff_ffff,
              32'sh8000_0000, 32'shfffe_0000, 50, 2, 1'b0);
    run_phase({MODE_W{1'b1}}, 17'd0, RST_CLIP_LEVEL, RST_LEAK_SLOPE, RST_SWISH_OFFSET,
              RST_SWISH_INV_SCALE, RST_SWISH_LIMIT, 60, 3, 1'b1);
    run_phase(ACT_HSWISH + 3'd1, 17'h1_ffff, RST_CLIP_LEVEL, RST_LEAK_SLOPE,
              RST_SWISH_OFFSET, RST_SWISH_INV_SCALE, RST_SWISH_LIMIT, 40, 0, 1'b0);
    run_phase(ACT_RELU, PLANE_CFG_W'(MAX_PLANE_DEF), RST_CLIP_LEVEL, RST_LEAK_SLOPE,
              RST_SWISH_OFFSET, RST_SWISH_INV_SCALE, RST_SWISH_LIMIT, 30, 0, 1'b0);

    repeat (5) begin
      case ($urandom_range(0, 7))
        0:       plane = '0;
        1:       plane = 17'h1_ffff;
        2:       plane = PLANE_CFG_W'(MAX_PLANE_DEF);
        3:       plane = PLANE_CFG_W'($urandom_range(0, 17'h1_ffff));
        default: plane = PLANE_CFG_W'($urandom_range(1, 12));
      endcase
      run_phase(MODE_W'($urandom_range(0, 7)), plane, rand_q(), rand_q(), rand_q(),
                rand_q(), rand_q(), 50, $urandom_range(0, 5), 1'b0);
    end

    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** bias_activation_layout_unblock: PASSED **");
    end else begin
      $display("** bias_activation_layout_unblock: FAILED **");
    end
    $finish;
  end
endmodule
